FILE: rtl/core/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared widths, function and register codes, and the command and status
// bundles that pass between the deframer controller and its datapath.
// ----------------------------------------------------------------------------
package tpd_pkg;

	localparam int FUNC_W     = 2;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 6;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int TBL_DEPTH  = 256;

	// Item function codes.
	localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POLL = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TBL  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TERM    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b1;

	localparam logic [BYTE_W-1:0] TERM_RST    = 8'h00;
	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd8000;

	// Which address the ring read port takes.
	typedef enum logic [1:0] {
		RD_HEAD = 2'd0,
		RD_TAIL = 2'd1,
		RD_WALK = 2'd2
	} rd_sel_t;

	// What the result register is loaded with.
	typedef enum logic [1:0] {
		OUT_ALARM = 2'd0,
		OUT_OVF   = 2'd1,
		OUT_DATA  = 2'd2
	} out_sel_t;

	typedef struct packed {
		logic     push;
		logic     tbl_wr;
		logic     now_load;
		logic     ring_rd;
		rd_sel_t  rd_sel;
		logic     tbl_rd;
		logic     idx_clr;
		logic     idx_inc;
		logic     out_load;
		out_sel_t out_sel;
		logic     pop_one;
		logic     pop_len;
	} tpd_cmd_t;

	typedef struct packed {
		logic ring_full;
		logic ring_empty;
		logic alarm_hit;
		logic len_zero;
		logic len_short;
		logic term_match;
		logic is_last;
		logic out_free;
	} tpd_sts_t;

endpackage

FILE: rtl/core/tpd_ifs.sv
// ----------------------------------------------------------------------------
// tpd_ifs
// Valid/ready channels of the deframer: the item channel and the result
// channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface tpd_in_if;
	logic                        valid;
	logic                        ready;
	logic [tpd_pkg::FUNC_W-1:0]  func;
	logic [tpd_pkg::BYTE_W-1:0]  data_byte;
	logic [tpd_pkg::LEN_W-1:0]   length_value;
	logic [tpd_pkg::TIME_W-1:0]  now_time;

	modport source (output valid, func, data_byte, length_value, now_time, input ready);
	modport sink   (input valid, func, data_byte, length_value, now_time, output ready);
endinterface

interface tpd_out_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [tpd_pkg::BYTE_W-1:0]  packet_byte;
	logic                        packet_end;
	logic                        stop_alarm;
	logic                        overflow;

	modport source (output valid, kind, packet_byte, packet_end, stop_alarm, overflow,
		input ready);
	modport sink   (input valid, kind, packet_byte, packet_end, stop_alarm, overflow,
		output ready);
endinterface

FILE: rtl/core/tpd_ctrl.sv
// ----------------------------------------------------------------------------
// tpd_ctrl
// Sequencer of the deframer: takes items, walks a poll through the watchdog,
// head lookup, terminator check and packet streaming.
// ----------------------------------------------------------------------------
module tpd_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [tpd_pkg::FUNC_W-1:0] in_func,
	output logic                       in_ready,
	input  tpd_pkg::tpd_sts_t          sts,
	output tpd_pkg::tpd_cmd_t          cmd
);
	import tpd_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_OVF     = 8'b0000_0010,
		S_ALARM   = 8'b0000_0100,
		S_HEAD    = 8'b0000_1000,
		S_LOOK    = 8'b0001_0000,
		S_CHKLEN  = 8'b0010_0000,
		S_CHKTERM = 8'b0100_0000,
		S_EMIT    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rd_sel  = RD_HEAD;
		cmd.out_sel = OUT_DATA;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (in_func)
						FUNC_BYTE: begin
							if (sts.ring_full) begin
								state_d = S_OVF;
							end else begin
								cmd.push = 1'b1;
							end
						end
						FUNC_POLL: begin
							cmd.now_load = 1'b1;
							if (sts.alarm_hit) begin
								state_d = S_ALARM;
							end else if (!sts.ring_empty) begin
								state_d = S_HEAD;
							end
						end
						FUNC_TBL: begin
							cmd.tbl_wr = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_OVF: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_OVF;
					state_d      = S_IDLE;
				end
			end
			S_ALARM: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_ALARM;
					state_d      = sts.ring_empty ? S_IDLE : S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.ring_rd = 1'b1;
				cmd.rd_sel  = RD_HEAD;
				state_d     = S_LOOK;
			end
			S_LOOK: begin
				cmd.tbl_rd = 1'b1;
				state_d    = S_CHKLEN;
			end
			S_CHKLEN: begin
				if (sts.len_zero) begin
					cmd.pop_one = 1'b1;
					state_d     = S_IDLE;
				end else if (sts.len_short) begin
					state_d = S_IDLE;
				end else begin
					cmd.ring_rd = 1'b1;
					cmd.rd_sel  = RD_TAIL;
					state_d     = S_CHKTERM;
				end
			end
			S_CHKTERM: begin
				if (sts.term_match) begin
					cmd.ring_rd = 1'b1;
					cmd.rd_sel  = RD_HEAD;
					cmd.idx_clr = 1'b1;
					state_d     = S_EMIT;
				end else begin
					cmd.pop_one = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_DATA;
					if (sts.is_last) begin
						cmd.pop_len = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.ring_rd = 1'b1;
						cmd.rd_sel  = RD_WALK;
						cmd.idx_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/tpd_datapath.sv
// ----------------------------------------------------------------------------
// tpd_datapath
// Ring memory with its pointers, the header length table, the watchdog
// compare, configuration registers and the result register.
// ----------------------------------------------------------------------------
module tpd_datapath #(
	parameter int RING_DEPTH = 64,
	parameter int MAX_PACKET = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tpd_pkg::tpd_cmd_t              cmd,
	output tpd_pkg::tpd_sts_t              sts,
	input  logic                           cfg_we,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [tpd_pkg::BYTE_W-1:0]     data_byte,
	input  logic [tpd_pkg::LEN_W-1:0]      length_value,
	input  logic [tpd_pkg::TIME_W-1:0]     now_time,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic                           kind,
	output logic [tpd_pkg::BYTE_W-1:0]     packet_byte,
	output logic                           packet_end,
	output logic                           stop_alarm,
	output logic                           overflow
);
	import tpd_pkg::*;

	localparam int PW      = $clog2(RING_DEPTH);
	localparam int CW      = $clog2(RING_DEPTH + 1);
	localparam int SW      = (PW + 1 > LEN_W + 1) ? PW + 1 : LEN_W + 1;
	localparam int LEN_CAP = (MAX_PACKET < RING_DEPTH) ? MAX_PACKET : RING_DEPTH;
	localparam logic [LEN_W-1:0] CAP_L   = LEN_W'(LEN_CAP);
	localparam logic [SW-1:0]    DEPTH_S = SW'(RING_DEPTH);
	localparam logic [CW-1:0]    DEPTH_C = CW'(RING_DEPTH);

	logic [BYTE_W-1:0]    ring [RING_DEPTH];
	logic [LEN_W-1:0]     tbl  [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] tbl_vld_q;

	logic [BYTE_W-1:0] term_q;
	logic [TIME_W-1:0] timeout_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] now_q;
	logic [PW-1:0]     rd_pos_q, wr_pos_q, ptr_q;
	logic [CW-1:0]     fill_q;
	logic [LEN_W-1:0]  idx_q;
	logic [BYTE_W-1:0] ring_rd_q;
	logic [LEN_W-1:0]  tbl_rd_q;
	logic              tbl_vld_rd_q;
	logic              out_valid_q;
	logic              kind_q, end_q, alarm_q, ovf_q;
	logic [BYTE_W-1:0] byte_q;

	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  len_sat;
	logic [PW-1:0]     rd_addr;
	logic [PW-1:0]     tail_addr;
	logic [PW-1:0]     next_pos;
	logic [TIME_W:0]   limit;

	// Reduce a sum below twice the depth back into the ring.
	function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s >= DEPTH_S) ? s - DEPTH_S : s;
		return r[PW-1:0];
	endfunction

	assign len       = tbl_vld_rd_q ? tbl_rd_q : '0;
	assign len_sat   = (length_value > CAP_L) ? CAP_L : length_value;
	assign tail_addr = wrap(SW'(rd_pos_q) + SW'(len) - SW'(1));
	assign next_pos  = wrap(SW'(rd_pos_q) + SW'(len));
	assign limit     = {1'b0, last_q} + {1'b0, timeout_q};

	always_comb begin
		case (cmd.rd_sel)
			RD_HEAD: rd_addr = rd_pos_q;
			RD_TAIL: rd_addr = tail_addr;
			RD_WALK: rd_addr = ptr_q;
			default: rd_addr = rd_pos_q;
		endcase
	end

	assign sts.ring_full  = (fill_q == DEPTH_C);
	assign sts.ring_empty = (fill_q == '0);
	assign sts.alarm_hit  = ({1'b0, now_time} >= limit);
	assign sts.len_zero   = (len == '0);
	assign sts.len_short  = (SW'(fill_q) < SW'(len));
	assign sts.term_match = (ring_rd_q == term_q);
	assign sts.is_last    = (idx_q == len - LEN_W'(1));
	assign sts.out_free   = !out_valid_q || res_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q    <= TERM_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TERM:    term_q    <= cfg_data[BYTE_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Ring pointers, fill count and delivery time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pos_q <= '0;
			wr_pos_q <= '0;
			fill_q   <= '0;
			last_q   <= '0;
		end else begin
			if (cmd.push) begin
				wr_pos_q <= wrap(SW'(wr_pos_q) + SW'(1));
				fill_q   <= fill_q + CW'(1);
			end else if (cmd.pop_one) begin
				rd_pos_q <= wrap(SW'(rd_pos_q) + SW'(1));
				fill_q   <= fill_q - CW'(1);
			end else if (cmd.pop_len) begin
				rd_pos_q <= next_pos;
				fill_q   <= fill_q - CW'(len);
				last_q   <= now_q;
			end
		end
	end

	// Ring memory, registered read.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring[wr_pos_q] <= data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ring_rd) begin
			ring_rd_q <= ring[rd_addr];
			ptr_q     <= wrap(SW'(rd_addr) + SW'(1));
		end
		if (cmd.now_load) begin
			now_q <= now_time;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + LEN_W'(1);
		end
	end

	// Length table: an entry not yet written reads as not a header.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (cmd.tbl_wr) begin
			tbl_vld_q[data_byte] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr) begin
			tbl[data_byte] <= len_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_rd) begin
			tbl_rd_q     <= tbl[ring_rd_q];
			tbl_vld_rd_q <= tbl_vld_q[ring_rd_q];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_sel)
				OUT_ALARM: begin
					kind_q  <= 1'b0;
					byte_q  <= '0;
					end_q   <= 1'b0;
					alarm_q <= 1'b1;
					ovf_q   <= 1'b0;
				end
				OUT_OVF: begin
					kind_q  <= 1'b0;
					byte_q  <= '0;
					end_q   <= 1'b0;
					alarm_q <= 1'b0;
					ovf_q   <= 1'b1;
				end
				default: begin
					kind_q  <= 1'b1;
					byte_q  <= ring_rd_q;
					end_q   <= sts.is_last;
					alarm_q <= 1'b0;
					ovf_q   <= 1'b0;
				end
			endcase
		end
	end

	assign res_valid   = out_valid_q;
	assign kind        = kind_q;
	assign packet_byte = byte_q;
	assign packet_end  = end_q;
	assign stop_alarm  = alarm_q;
	assign overflow    = ovf_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count above ring depth");

	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !(cmd.pop_one || cmd.pop_len))
		else $error("ring pushed and popped in the same cycle");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || res_ready))
		else $error("result register overwritten before transfer");

	a_delivery_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_len |=> (last_q == $past(now_q)))
		else $error("delivery time not recorded");

endmodule

FILE: rtl/core/typed_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// typed_packet_deframer_core
// Received-byte ring with a length-table deframer and a link-loss watchdog.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Carries
//  in_ch     sink       valid/ready        func, data_byte, length_value, now_time
//  out_ch    source     valid/ready        kind, packet_byte, packet_end,
//                                          stop_alarm, overflow
//  cfg       write      cfg_we             cfg_index, cfg_data (32 bits)
//
//  A table write, a byte item into a ring with room, and a poll on an empty
//  ring with no alarm are done in the cycle they are accepted. Other polls
//  then pass the head read, table lookup and length check states, the
//  terminator read when a complete packet is held, and one delivered packet
//  byte per cycle while the result register is free, as the single ring read
//  port walks the packet. Watchdog and overflow status load in their own state.
//  Reset is asynchronous and active low; the length table is cleared at once
//  by per-entry valid bits, so no clearing pass follows reset.
//  The result register holds a finished result until its transfer, and the
//  sequencer stalls in place while that register is full and not taken.
//
// ----------------------------------------------------------------------------
module typed_packet_deframer_core #(
	parameter int RING_DEPTH = 64,
	parameter int MAX_PACKET = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_data,
	tpd_in_if.sink                         in_ch,
	tpd_out_if.source                      out_ch
);
	import tpd_pkg::*;

	// Commands from the sequencer and status back from the datapath.
	tpd_cmd_t cmd;
	tpd_sts_t sts;

	// The sequencer owns item acceptance: a transfer on the item channel
	// only happens while it sits idle.
	tpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_func  (in_ch.func),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds all storage and drives the result channel from its
	// result register.
	tpd_datapath #(
		.RING_DEPTH (RING_DEPTH),
		.MAX_PACKET (MAX_PACKET)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.data_byte    (in_ch.data_byte),
		.length_value (in_ch.length_value),
		.now_time     (in_ch.now_time),
		.res_valid    (out_ch.valid),
		.res_ready    (out_ch.ready),
		.kind         (out_ch.kind),
		.packet_byte  (out_ch.packet_byte),
		.packet_end   (out_ch.packet_end),
		.stop_alarm   (out_ch.stop_alarm),
		.overflow     (out_ch.overflow)
	);

endmodule
